/* src/rle_color_key_filter_unit_defines.svh */
// assertion macros for the run-length color key filter
// used by the port checker; clocked on i_clk, reset i_rst_n
`ifndef RLE_COLOR_KEY_FILTER_UNIT_DEFINES_SVH
`define RLE_COLOR_KEY_FILTER_UNIT_DEFINES_SVH

// checked outside reset only
`define RCKF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define RCKF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* src/rckf_pkg.sv */
// shared types and constants of the run-length color key filter
// no dependencies
package rckf_pkg;

    localparam logic [15:0] KEY_COLOR    = 16'h7c00;
    localparam logic [15:0] FILL_COLOR   = 16'hf81f;
    localparam logic [7:0]  SKIP_COMMAND = 8'd255;

    localparam int QUEUE_AW    = 3;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_TRAILING    = 3'd1;
    localparam logic [2:0] ERR_SKIP_TRUNC  = 3'd2;
    localparam logic [2:0] ERR_SKIP_OVER   = 3'd3;
    localparam logic [2:0] ERR_LIT_OVER    = 3'd4;
    localparam logic [2:0] ERR_LIT_TRUNC   = 3'd5;

    typedef enum logic [3:0] {
        PH_CMD  = 4'b0001,
        PH_SKIP = 4'b0010,
        PH_LOW  = 4'b0100,
        PH_HIGH = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       stream_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_present;
        logic        run_last;
        logic        stream_done;
        logic [31:0] red_pixel_count;
        logic [2:0]  fault_code;
    } t_out_word;

endpackage

/* src/rle_color_key_filter_unit.sv */
// top level of the run-length color key filter: parser, frame registers, result queue
// depends on rckf_pkg
//
// Takes one stream byte per cycle while ready and produces up to three result words for it
// (a literal high byte gives two, the last byte adds a status word). Results go out one per
// cycle, unless the output is stalled, from an eight-entry result queue; the input is ready
// whenever at least three queue entries are free, so the sustained byte rate is set by the
// output side. The input is held off in the cycle after each register write while the frame
// pixel count is recomputed.
module rle_color_key_filter_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rckf_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rckf_pkg::t_out_word o_out_word,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    localparam int AW = rckf_pkg::QUEUE_AW;

    logic [15:0] r_width;
    logic [15:0] r_height;
    logic [31:0] r_pixels;
    logic        r_cfg_hold;

    rckf_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_cursor, n_cursor;
    logic [7:0]  r_words, n_words;
    logic [7:0]  r_held, n_held;
    logic [31:0] r_hits, n_hits;
    logic [2:0]  r_fault, n_fault;

    rckf_pkg::t_out_word r_queue [rckf_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_count, n_count;

    rckf_pkg::t_out_word res [3];
    logic [1:0]  res_n;
    logic [7:0]  byte_v [2];
    logic [1:0]  byte_n;
    logic [31:0] remaining;
    logic        byte_over;
    logic [15:0] word;
    logic        accept;
    logic        pop;
    logic [1:0]  push;

    assign accept     = i_in_valid && o_in_ready;
    assign pop        = o_out_valid && i_out_ready;
    assign push       = accept ? res_n : 2'd0;
    assign o_in_ready = (r_count <= (AW+1)'(rckf_pkg::QUEUE_DEPTH - 3)) && !r_cfg_hold;
    assign o_out_valid = r_count != '0;
    assign o_out_word  = r_queue[r_rd];

    assign remaining = (r_cursor < r_pixels) ? r_pixels - r_cursor : 32'd0;
    assign byte_over = {24'd0, i_in_word.stream_byte} > remaining;
    assign word      = {i_in_word.stream_byte, r_held};

    // frame registers and pixel count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= 16'd1;
            r_height   <= 16'd1;
            r_pixels   <= 32'd1;
            r_cfg_hold <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rckf_pkg::REG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                    rckf_pkg::REG_FRAME_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            r_pixels   <= 32'(r_width) * 32'(r_height);
            r_cfg_hold <= i_cfg_we;
        end
    end

    // parser next state and results of the current word
    always_comb begin
        n_phase  = r_phase;
        n_cursor = r_cursor;
        n_words  = r_words;
        n_held   = r_held;
        n_hits   = r_hits;
        n_fault  = r_fault;
        byte_v[0] = 8'd0;
        byte_v[1] = 8'd0;
        byte_n    = 2'd0;
        res[0]    = '0;
        res[1]    = '0;
        res[2]    = '0;
        res_n     = 2'd0;

        if (r_fault == rckf_pkg::ERR_NONE) begin
            case (r_phase)
                rckf_pkg::PH_CMD: begin
                    if (remaining == 32'd0) begin
                        n_fault = rckf_pkg::ERR_TRAILING;
                    end else if (i_in_word.stream_byte == rckf_pkg::SKIP_COMMAND) begin
                        n_phase   = rckf_pkg::PH_SKIP;
                        byte_v[0] = i_in_word.stream_byte;
                        byte_n    = 2'd1;
                    end else if (byte_over) begin
                        n_fault = rckf_pkg::ERR_LIT_OVER;
                    end else begin
                        byte_v[0] = i_in_word.stream_byte;
                        byte_n    = 2'd1;
                        if (i_in_word.stream_byte != 8'd0) begin
                            n_words = i_in_word.stream_byte;
                            n_phase = rckf_pkg::PH_LOW;
                        end
                    end
                end
                rckf_pkg::PH_SKIP: begin
                    if (byte_over) begin
                        n_fault = rckf_pkg::ERR_SKIP_OVER;
                    end else begin
                        n_cursor  = r_cursor + {24'd0, i_in_word.stream_byte};
                        n_phase   = rckf_pkg::PH_CMD;
                        byte_v[0] = i_in_word.stream_byte;
                        byte_n    = 2'd1;
                    end
                end
                rckf_pkg::PH_LOW: begin
                    n_held  = i_in_word.stream_byte;
                    n_phase = rckf_pkg::PH_HIGH;
                end
                rckf_pkg::PH_HIGH: begin
                    if (word == rckf_pkg::KEY_COLOR) begin
                        n_hits    = r_hits + 32'd1;
                        byte_v[0] = word[7:0];
                        byte_v[1] = word[15:8];
                    end else begin
                        byte_v[0] = rckf_pkg::FILL_COLOR[7:0];
                        byte_v[1] = rckf_pkg::FILL_COLOR[15:8];
                    end
                    byte_n   = 2'd2;
                    n_cursor = r_cursor + 32'd1;
                    n_words  = r_words - 8'd1;
                    n_phase  = (n_words == 8'd0) ? rckf_pkg::PH_CMD : rckf_pkg::PH_LOW;
                end
                default: begin
                    n_phase = rckf_pkg::PH_CMD;
                end
            endcase
        end

        for (int k = 0; k < 2; k++) begin
            res[k].out_byte        = byte_v[k];
            res[k].byte_present    = 2'(k) < byte_n;
            res[k].red_pixel_count = n_hits;
            res[k].fault_code      = n_fault;
        end
        res_n = byte_n;

        if (i_in_word.stream_last && n_fault == rckf_pkg::ERR_NONE) begin
            if (n_phase == rckf_pkg::PH_SKIP) begin
                n_fault = rckf_pkg::ERR_SKIP_TRUNC;
            end else if (n_phase == rckf_pkg::PH_LOW || n_phase == rckf_pkg::PH_HIGH) begin
                n_fault = rckf_pkg::ERR_LIT_TRUNC;
            end
        end

        if (i_in_word.stream_last) begin
            res[byte_n]                 = '0;
            res[byte_n].stream_done     = 1'b1;
            res[byte_n].red_pixel_count = n_hits;
            res[byte_n].fault_code      = n_fault;
            res_n    = byte_n + 2'd1;
            n_phase  = rckf_pkg::PH_CMD;
            n_cursor = 32'd0;
            n_words  = 8'd0;
            n_held   = 8'd0;
            n_hits   = 32'd0;
            n_fault  = rckf_pkg::ERR_NONE;
        end

        for (int k = 0; k < 3; k++) begin
            if (res_n != 2'd0 && 2'(k) == res_n - 2'd1) begin
                res[k].run_last = 1'b1;
            end
        end

        n_count = r_count + (AW+1)'(push) - (AW+1)'(pop);
    end

    // parser state and queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= rckf_pkg::PH_CMD;
            r_cursor <= 32'd0;
            r_words  <= 8'd0;
            r_held   <= 8'd0;
            r_hits   <= 32'd0;
            r_fault  <= rckf_pkg::ERR_NONE;
            r_wr     <= '0;
            r_rd     <= '0;
            r_count  <= '0;
        end else begin
            if (accept) begin
                r_phase  <= n_phase;
                r_cursor <= n_cursor;
                r_words  <= n_words;
                r_held   <= n_held;
                r_hits   <= n_hits;
                r_fault  <= n_fault;
            end
            r_wr    <= r_wr + AW'(push);
            r_rd    <= r_rd + AW'(pop);
            r_count <= n_count;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (accept && 2'(k) < res_n) begin
                r_queue[r_wr + AW'(k)] <= res[k];
            end
        end
    end

endmodule

/* src/rckf_checker.sv */
// port-level checker for the run-length color key filter, bound to the top level
// depends on rckf_pkg and rle_color_key_filter_unit_defines.svh
`include "rle_color_key_filter_unit_defines.svh"

module rckf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input rckf_pkg::t_out_word o_out_word
);

    `RCKF_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

    `RCKF_ASSERT(a_byte_or_status, o_out_valid |-> !(o_out_word.byte_present && o_out_word.stream_done), "status word carries a byte")

    `RCKF_ASSERT(a_status_ends_run, (o_out_valid && o_out_word.stream_done) |-> o_out_word.run_last, "status word not last of its run")

    `RCKF_ASSERT(a_error_range, o_out_valid |-> (o_out_word.fault_code <= rckf_pkg::ERR_LIT_TRUNC), "error code out of range")

    `RCKF_ASSERT(a_out_hold, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)), "stalled output word changed")

endmodule

bind rle_color_key_filter_unit rckf_checker u_rckf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
